// ----- hdl/srsk_pkg.sv -----
// Shared types and constants for the stable record sorter.
package srsk_pkg;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int KEY_W           = 16;
    localparam int PAYLOAD_W       = 32;
    localparam int REC_W           = KEY_W + PAYLOAD_W;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } record_t;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic                 last_in;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]     sorted_key;
        logic [PAYLOAD_W-1:0] sorted_payload;
        logic                 last_out;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_START,
        ST_SORT,
        ST_EMIT_RD,
        ST_EMIT_HOLD
    } state_t;

endpackage

// ----- hdl/srsk_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module srsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/srsk_sorter.sv -----
// Bubble sort sequencer working in place on the record RAM, one compare per cycle.
module srsk_sorter
    import srsk_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    localparam int AW = $clog2(MAX_RECORDS),
    localparam int CW = $clog2(MAX_RECORDS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [CW-1:0] count,
    output logic          done,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  record_t       rd_data,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output record_t       wr_data
);

    localparam int SW = $clog2(MAX_RECORDS + 2);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW-1:0] len_reg, len_next;
    logic [SW-1:0] step_reg, step_next;
    record_t       cur_reg, cur_next;
    logic [SW-1:0] step_m2, len_m1, len_p1;

    assign step_m2 = step_reg - SW'(2);
    assign len_m1  = len_reg - SW'(1);
    assign len_p1  = len_reg + SW'(1);

    // The running record cur_reg carries the larger key along the pass; the smaller
    // of the pair is written back two places behind the read pointer.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        len_next  = len_reg;
        step_next = step_reg;
        cur_next  = cur_reg;
        rd_en     = 1'b0;
        rd_addr   = step_reg[AW-1:0];
        wr_en     = 1'b0;
        wr_addr   = step_m2[AW-1:0];
        wr_data   = cur_reg;
        if (start)
        begin
            busy_next = (count >= CW'(2));
            done_next = (count < CW'(2));
            len_next  = SW'(count);
            step_next = '0;
        end
        else if (busy_reg)
        begin
            rd_en     = (step_reg < len_reg);
            step_next = step_reg + SW'(1);
            if (step_reg == SW'(1))
            begin
                cur_next = rd_data;
            end
            else if (step_reg >= SW'(2) && step_reg <= len_reg)
            begin
                wr_en = 1'b1;
                if (cur_reg.key > rd_data.key)
                begin
                    wr_data = rd_data;
                end
                else
                begin
                    wr_data  = cur_reg;
                    cur_next = rd_data;
                end
            end
            else if (step_reg == len_p1)
            begin
                // End of pass: the largest record settles at the top of the range.
                wr_en     = 1'b1;
                wr_addr   = len_m1[AW-1:0];
                wr_data   = cur_reg;
                step_next = '0;
                len_next  = len_m1;
                if (len_m1 < SW'(2))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            len_reg  <= '0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            len_reg  <= len_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    assign done = done_reg;

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("sorter reads and writes the same entry in one cycle");

    a_pass_len_floor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (len_reg >= SW'(2)))
        else $error("sorter running a pass shorter than two records");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("sort completion held for more than one cycle");

endmodule

// ----- hdl/stable_record_sort_by_key.sv -----
// After the last item of a list, the list passes through ST_START and is then sorted
// in place on the record RAM, one compare-exchange per cycle.
// Each sorted record is then read from the RAM (ST_EMIT_RD) and held at the output
// (ST_EMIT_HOLD) until out_ready accepts it. Loading takes one item per cycle while
// in_valid is high; no item is taken while a list is sorted or emitted.
// Reset (rst_n, asynchronous) empties the list; RAM contents are not cleared.
module stable_record_sort_by_key
    import srsk_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] emit_idx_reg, emit_idx_next;

    logic          in_acc, out_acc, has_room, emit_last;
    logic          sort_start, sort_done;
    logic          srt_rd_en, srt_wr_en;
    logic [AW-1:0] srt_rd_addr, srt_wr_addr;
    record_t       srt_wr_data;

    logic          ram_wr_en, ram_rd_en;
    logic [AW-1:0] ram_wr_addr, ram_rd_addr;
    record_t       ram_wr_data;
    logic [REC_W-1:0] ram_rd_raw;
    record_t       ram_rd_data;

    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;
    assign has_room  = (count_reg < CW'(MAX_RECORDS));
    assign emit_last = (CW'(emit_idx_reg + CW'(1)) == count_reg);
    assign ram_rd_data = record_t'(ram_rd_raw);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_acc && in_item.last_in)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_SORT;
            end
            ST_SORT:
            begin
                if (sort_done)
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD:
            begin
                if (out_ready)
                begin
                    state_next = emit_last ? ST_COLLECT : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // Outputs and datapath control
    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        sort_start    = 1'b0;
        count_next    = count_reg;
        emit_idx_next = emit_idx_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = count_reg[AW-1:0];
        ram_wr_data   = '{key: in_item.key, payload: in_item.payload};
        ram_rd_en     = 1'b0;
        ram_rd_addr   = emit_idx_reg[AW-1:0];
        case (state_reg)
            ST_COLLECT:
            begin
                in_ready = 1'b1;
                // An item beyond capacity is dropped, but its last mark still counts.
                if (in_acc && has_room)
                begin
                    ram_wr_en  = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                emit_idx_next = '0;
            end
            ST_START:
            begin
                sort_start = 1'b1;
            end
            ST_SORT:
            begin
                ram_wr_en   = srt_wr_en;
                ram_wr_addr = srt_wr_addr;
                ram_wr_data = srt_wr_data;
                ram_rd_en   = srt_rd_en;
                ram_rd_addr = srt_rd_addr;
            end
            ST_EMIT_RD:
            begin
                ram_rd_en = 1'b1;
            end
            ST_EMIT_HOLD:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    emit_idx_next = emit_idx_reg + CW'(1);
                    if (emit_last)
                    begin
                        count_next = '0;
                    end
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign out_item = '{sorted_key:     ram_rd_data.key,
                        sorted_payload: ram_rd_data.payload,
                        last_out:       emit_last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_COLLECT;
            count_reg    <= '0;
            emit_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            emit_idx_reg <= emit_idx_next;
        end
    end

    srsk_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_raw)
    );

    srsk_sorter #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_sorter (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sort_start),
        .count   (count_reg),
        .done    (sort_done),
        .rd_en   (srt_rd_en),
        .rd_addr (srt_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (srt_wr_en),
        .wr_addr (srt_wr_addr),
        .wr_data (srt_wr_data)
    );

    a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a sorted item is being offered");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RECORDS))
        else $error("record count beyond capacity");

    a_done_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
        sort_done |-> (state_reg == ST_SORT))
        else $error("sort completion outside the sort phase");

    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && out_item.last_out) |=> (count_reg == '0) && in_ready)
        else $error("list not emptied after its final item");

endmodule

// ----- dv/tb_stable_record_sort_by_key.sv -----
// Self-checking testbench for the stable record sorter: table-driven and random lists.
module tb_stable_record_sort_by_key
    import srsk_pkg::*;
();

    localparam int MAX_RECS    = MAX_RECORDS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 60;
    localparam int LONG_HOLD   = 400;

    typedef enum int {
        KEYS_NARROW,
        KEYS_FULL,
        KEYS_EDGES
    } key_mode_t;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic                 last;
        logic                 typed;
        logic [KEY_W-1:0]     exp_key;
        logic [PAYLOAD_W-1:0] exp_payload;
    } dir_row_t;

    // Rows with typed set are single-record lists, whose record comes straight back.
    dir_row_t dir_rows [22] = '{
        '{16'h0000, 32'h0000_0000, 1'b1, 1'b1, 16'h0000, 32'h0000_0000},
        '{16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF},
        '{16'h1234, 32'hA5A5_A5A5, 1'b1, 1'b1, 16'h1234, 32'hA5A5_A5A5},
        '{16'h0002, 32'h0000_0002, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'h0001, 32'h0000_0001, 1'b1, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'hFFFF, 32'h1111_1111, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'h8000, 32'h2222_2222, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'h0100, 32'h3333_3333, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'h0001, 32'h4444_4444, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'h0000, 32'h5555_5555, 1'b1, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'h0000, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'h0001, 32'hFFFF_0000, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'h0002, 32'h0000_FFFF, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'hFFFF, 32'h1234_5678, 1'b1, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'h0042, 32'h0000_0001, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'h0042, 32'h0000_0002, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'h0041, 32'h0000_0003, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'h0042, 32'h0000_0004, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'h0041, 32'h0000_0005, 1'b1, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'hFFFF, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'h0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
        '{16'hFFFF, 32'h5555_5555, 1'b1, 1'b0, 16'h0000, 32'h0000_0000}
    };

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    logic [KEY_W-1:0]     list_keys     [MAX_RECS];
    logic [PAYLOAD_W-1:0] list_payloads [MAX_RECS];
    logic [6:0]           list_len;
    out_item_t            pending_sorted [$];

    int error_count;
    int cycle_count;
    int rand_items;
    int stall_left;
    int hold_left;
    bit no_idle;
    bit list_quiet;
    bit arm_hold;
    bit hold_start;

    stable_record_sort_by_key #(
        .MAX_RECORDS(MAX_RECS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stores the record, and on the last item sorts the list stably and, if keep is set, queues it.
    task automatic take_record(input in_item_t rec, input bit keep);
        logic [KEY_W-1:0]     tk;
        logic [PAYLOAD_W-1:0] tp;
        out_item_t            res;
        if (list_len < MAX_RECS)
        begin
            list_keys[list_len[$clog2(MAX_RECS)-1:0]]     = rec.key;
            list_payloads[list_len[$clog2(MAX_RECS)-1:0]] = rec.payload;
            list_len++;
        end
        if (rec.last_in)
        begin
            for (int pass = 0; pass + 1 < list_len; pass++)
            begin
                for (int pos = 0; pos + 1 < list_len - pass; pos++)
                begin
                    if (list_keys[pos] > list_keys[pos + 1])
                    begin
                        tk = list_keys[pos];
                        tp = list_payloads[pos];
                        list_keys[pos]         = list_keys[pos + 1];
                        list_payloads[pos]     = list_payloads[pos + 1];
                        list_keys[pos + 1]     = tk;
                        list_payloads[pos + 1] = tp;
                    end
                end
            end
            for (int k = 0; k < list_len; k++)
            begin
                res.sorted_key     = list_keys[k];
                res.sorted_payload = list_payloads[k];
                res.last_out       = (k + 1 == list_len);
                if (keep)
                    pending_sorted.push_back(res);
            end
            list_len = '0;
        end
    endtask

    function automatic int idle_gap();
        if (no_idle || list_quiet)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(1, 13);
        return 0;
    endfunction

    task automatic drive_item(input in_item_t rec, input bit keep);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= rec;
        do
            @(posedge clk);
        while (!in_ready);
        take_record(rec, keep);
    endtask

    task automatic send_list(input int len, input key_mode_t mode);
        in_item_t rec;
        list_quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                KEYS_NARROW: rec.key = KEY_W'($urandom_range(0, 3));
                KEYS_EDGES:
                    case ($urandom_range(0, 4))
                        0: rec.key = 16'h0000;
                        1: rec.key = 16'hFFFF;
                        2: rec.key = 16'h7FFF;
                        3: rec.key = 16'h8000;
                        default: rec.key = KEY_W'($urandom);
                    endcase
                default: rec.key = KEY_W'($urandom);
            endcase
            rec.payload = $urandom;
            rec.last_in = (i == len - 1);
            drive_item(rec, 1'b1);
            rand_items++;
        end
    endtask

    initial
    begin
        in_item_t  rec;
        out_item_t res;
        int        len;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        list_len    = '0;
        error_count = 0;
        rand_items  = 0;
        no_idle     = 1'b0;
        list_quiet  = 1'b0;
        arm_hold    = 1'b0;
        hold_start  = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            rec.key     = dir_rows[i].key;
            rec.payload = dir_rows[i].payload;
            rec.last_in = dir_rows[i].last;
            drive_item(rec, !dir_rows[i].typed);
            if (dir_rows[i].typed)
            begin
                res.sorted_key     = dir_rows[i].exp_key;
                res.sorted_payload = dir_rows[i].exp_payload;
                res.last_out       = 1'b1;
                pending_sorted.push_back(res);
            end
        end

        // Overfull list: the store fills up, and the last item and the two before it
        // are dropped. Its output is held back for a long stretch while the next list
        // is already being offered.
        send_list(MAX_RECS + 3, KEYS_NARROW);
        arm_hold = 1'b1;

        while (rand_items < MAX_RECS + 3 + RAND_ITEMS)
        begin
            if (rand_items >= MAX_RECS + 3 + RAND_ITEMS - 30)
                no_idle = 1'b1;
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(11, 40);
            else
                len = $urandom_range(1, 10);
            send_list(len, key_mode_t'($urandom_range(0, 2)));
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_sorted.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0 && pending_sorted.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Output side: random stall bursts, plus one long hold-off when armed.
    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!no_idle && !list_quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_sorted.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected sorted record: key %h payload %h last %b",
                             out_item.sorted_key, out_item.sorted_payload, out_item.last_out);
            end
            else
            begin
                want = pending_sorted.pop_front();
                if (out_item.sorted_key !== want.sorted_key
                    || out_item.sorted_payload !== want.sorted_payload
                    || out_item.last_out !== want.last_out)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("sorted record mismatch: expected %h %h %b, got %h %h %b",
                                 want.sorted_key, want.sorted_payload, want.last_out,
                                 out_item.sorted_key, out_item.sorted_payload,
                                 out_item.last_out);
                end
            end
        end
        if (arm_hold && out_valid)
        begin
            arm_hold   = 1'b0;
            hold_start = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule

// ----- files.f -----
hdl/srsk_pkg.sv
hdl/srsk_ram.sv
hdl/srsk_sorter.sv
hdl/stable_record_sort_by_key.sv
dv/tb_stable_record_sort_by_key.sv
